// ===== src/p2p1d_pkg.sv =====
`timescale 1ns / 1ps
package p2p1d_pkg;

    // Result geometry
    localparam int OUT_W      = 48;
    localparam int ROW_W      = 2;
    localparam int NUM_COLS   = 6;
    localparam int FRAC_SHIFT = 11;
    localparam int RND_W      = 13;

    localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
    localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

    // Coefficient of the rotated edge n_k in entry (row, column)
    localparam logic [1:0] COEF_TAB [0:2][0:5][0:2] = '{
        '{'{2'd1, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0},
          '{2'd1, 2'd2, 2'd0}, '{2'd0, 2'd1, 2'd1}, '{2'd1, 2'd0, 2'd2}},
        '{'{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd1, 2'd0}, '{2'd0, 2'd0, 2'd0},
          '{2'd2, 2'd1, 2'd0}, '{2'd0, 2'd1, 2'd2}, '{2'd1, 2'd0, 2'd1}},
        '{'{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd0}, '{2'd0, 2'd0, 2'd1},
          '{2'd1, 2'd1, 2'd0}, '{2'd0, 2'd2, 2'd1}, '{2'd2, 2'd0, 2'd1}}
    };

    // floor((2048 * R + 1) / 3) for the residue sum R
    localparam logic [RND_W-1:0] RND_TAB [0:7] = '{
        13'd0, 13'd683, 13'd1365, 13'd2048, 13'd2731, 13'd3413, 13'd4096, 13'd4779
    };

endpackage

// ===== src/p2p1d_front.sv =====
`timescale 1ns / 1ps
module p2p1d_front #(
    parameter int COORD_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              direction,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_BITS-1:0]      vertex0_x,
    input  logic signed [COORD_BITS-1:0]      vertex0_y,
    input  logic signed [COORD_BITS-1:0]      vertex1_x,
    input  logic signed [COORD_BITS-1:0]      vertex1_y,
    input  logic signed [COORD_BITS-1:0]      vertex2_x,
    input  logic signed [COORD_BITS-1:0]      vertex2_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [3*(COORD_BITS+1)+6:0]       out_data
);
    import p2p1d_pkg::*;

    localparam int DW  = COORD_BITS + 1;     // edge difference width
    localparam int PW  = 2 * DW;             // product width
    localparam int UW  = COORD_BITS + 2;     // biased dividend width
    localparam int ND  = (UW + 7) / 8;       // byte digits of the dividend
    localparam int PDW = ND * 8;
    localparam int AW  = COORD_BITS + 1;     // quotient width
    localparam logic [UW-1:0]  BIAS  = UW'(3) << COORD_BITS;
    localparam logic [PDW-1:0] QBIAS = PDW'(1) << COORD_BITS;

    // Floor division by three, one byte digit per step; returns {rem, quotient}
    function automatic logic [AW+1:0] div3(input logic signed [DW-1:0] n);
        logic [UW-1:0]  u;
        logic [PDW-1:0] pad;
        logic [PDW-1:0] q;
        logic [1:0]     rem;
        logic [9:0]     v;
        logic [20:0]    prod;
        logic [7:0]     qd;
        logic [PDW-1:0] a;
        u   = UW'(n) + BIAS;
        pad = PDW'(u);
        q   = '0;
        rem = 2'd0;
        for (int d = ND - 1; d >= 0; d--)
        begin
            v    = {rem, pad[d*8 +: 8]};
            prod = 21'(v) * 21'd683;
            qd   = prod[18:11];
            rem  = 2'(v - 10'(qd) * 10'd3);
            q[d*8 +: 8] = qd;
        end
        a = q - QBIAS;
        return {rem, a[AW-1:0]};
    endfunction

    logic advance;

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [DW-1:0] dx1_reg, dy2_reg, dx2_reg, dy1_reg;
    logic signed [DW-1:0] n1_reg [0:2];
    logic signed [DW-1:0] n2_reg [0:2];
    logic signed [DW-1:0] n3_reg [0:2];
    logic signed [PW-1:0] p1_reg, p2_reg;
    logic                 deg3_reg;
    logic [3*AW+6:0]      data4_reg;

    logic signed [DW-1:0] n_next [0:2];
    logic [3*AW+6:0]      data4_next;
    logic [AW+1:0]        qr [0:2];

    assign advance   = !v4_reg || out_ready;
    assign in_ready  = advance;
    assign out_valid = v4_reg;
    assign out_data  = data4_reg;

    // Select the rotated opposite edges for the chosen derivative
    always_comb
    begin
        if (direction)
        begin
            n_next[0] = DW'(vertex2_x) - DW'(vertex1_x);
            n_next[1] = DW'(vertex0_x) - DW'(vertex2_x);
            n_next[2] = DW'(vertex1_x) - DW'(vertex0_x);
        end
        else
        begin
            n_next[0] = DW'(vertex1_y) - DW'(vertex2_y);
            n_next[1] = DW'(vertex2_y) - DW'(vertex0_y);
            n_next[2] = DW'(vertex0_y) - DW'(vertex1_y);
        end
    end

    // Split each oriented edge into quotient and residue by three
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            qr[k] = div3(n3_reg[k]);
        end
        data4_next = {deg3_reg,
                      qr[2][AW+1:AW], qr[1][AW+1:AW], qr[0][AW+1:AW],
                      qr[2][AW-1:0], qr[1][AW-1:0], qr[0][AW-1:0]};
    end

    // Advance the valid bits of the stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // Stage payloads: differences, products, orientation, division
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dx1_reg <= DW'(vertex1_x) - DW'(vertex0_x);
            dy2_reg <= DW'(vertex2_y) - DW'(vertex0_y);
            dx2_reg <= DW'(vertex2_x) - DW'(vertex0_x);
            dy1_reg <= DW'(vertex1_y) - DW'(vertex0_y);
            n1_reg  <= n_next;

            p1_reg  <= dx1_reg * dy2_reg;
            p2_reg  <= dx2_reg * dy1_reg;
            n2_reg  <= n1_reg;

            deg3_reg <= (p1_reg == p2_reg);
            for (int k = 0; k < 3; k++)
            begin
                n3_reg[k] <= (p1_reg < p2_reg) ? -n2_reg[k] : n2_reg[k];
            end

            data4_reg <= data4_next;
        end
    end

endmodule

// ===== src/p2p1d_queue.sv =====
`timescale 1ns / 1ps
module p2p1d_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    import p2p1d_pkg::*;

    logic [WIDTH-1:0] mem_reg [0:1];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Track pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

// ===== src/p2p1d_back.sv =====
`timescale 1ns / 1ps
module p2p1d_back #(
    parameter int COORD_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [3*(COORD_BITS+1)+6:0]         in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [p2p1d_pkg::ROW_W-1:0]         row_index,
    output logic [p2p1d_pkg::OUT_W*p2p1d_pkg::NUM_COLS-1:0] entries,
    output logic                                degenerate,
    output logic                                last_row
);
    import p2p1d_pkg::*;

    localparam int AW = COORD_BITS + 1;
    localparam int SW = AW + 2;        // width of a row sum of quotients

    logic signed [AW-1:0] a [0:2];
    logic [1:0]           r [0:2];
    logic                 deg;
    logic                 load;

    logic [ROW_W-1:0]          row_reg;
    logic                      valid_reg;
    logic [ROW_W-1:0]          row_out_reg;
    logic [OUT_W*NUM_COLS-1:0] entries_reg;
    logic                      deg_reg;
    logic                      last_reg;

    logic [OUT_W*NUM_COLS-1:0] entries_next;
    logic signed [SW-1:0]      qsum;
    logic [3:0]                rsum;
    logic [OUT_W-1:0]          ent;

    // Unpack the queue head
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            a[k] = in_data[k*AW +: AW];
            r[k] = in_data[3*AW + 2*k +: 2];
        end
        deg = in_data[3*AW+6];
    end

    assign load     = in_valid && (!valid_reg || out_ready);
    assign in_ready = load && (row_reg == ROW_LAST);

    // Form the six entries of the current row
    always_comb
    begin
        entries_next = '0;
        for (int j = 0; j < NUM_COLS; j++)
        begin
            qsum = '0;
            rsum = '0;
            for (int k = 0; k < 3; k++)
            begin
                if (COEF_TAB[row_reg][j][k] == 2'd2)
                    qsum = qsum + (SW'(a[k]) <<< 1);
                else if (COEF_TAB[row_reg][j][k] == 2'd1)
                    qsum = qsum + SW'(a[k]);
                rsum = rsum + 4'(COEF_TAB[row_reg][j][k]) * 4'(r[k]);
            end
            ent = (OUT_W'(qsum) <<< FRAC_SHIFT) + OUT_W'(RND_TAB[rsum[2:0]]);
            entries_next[j*OUT_W +: OUT_W] = deg ? '0 : ent;
        end
    end

    // Hold the row counter and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= ROW_FIRST;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
                row_reg <= (row_reg == ROW_LAST) ? ROW_FIRST : row_reg + 2'd1;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    // Register the output beat
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            row_out_reg <= row_reg;
            entries_reg <= entries_next;
            deg_reg     <= deg;
            last_reg    <= (row_reg == ROW_LAST);
        end
    end

    assign out_valid  = valid_reg;
    assign row_index  = row_out_reg;
    assign entries    = entries_reg;
    assign degenerate = deg_reg;
    assign last_row   = last_reg;

endmodule

// ===== src/p2_p1_divergence_element_matrix.sv =====
`timescale 1ns / 1ps
// A triangle passes through the front pipeline, the queue and the output register of the row stage;
// its first row then appears at the output, and the other two rows follow in order as the sink takes each.
// Each triangle occupies the output for its three result rows.
// Front pipeline (4 stages) and a 2-entry queue keep taking triangles while rows drain.
// Reset (rst_n, async, active low) clears pipeline, queue and row state; direction is 0.
module p2_p1_divergence_element_matrix #(
    parameter int COORD_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic                              cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y
    input  logic [((6*COORD_BITS+7)/8)*8-1:0] s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // row_index, entry0, entry1, entry2, entry3, entry4, entry5, zero pad
    output logic [295:0]                      m_tdata,
    // degenerate
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import p2p1d_pkg::*;

    localparam int QW = 3 * (COORD_BITS + 1) + 7;
    localparam int DATA_BITS = ROW_W + OUT_W * NUM_COLS;

    logic          direction_reg;
    logic          q_in_valid, q_in_ready;
    logic [QW-1:0] q_in_data;
    logic          q_out_valid, q_out_ready;
    logic [QW-1:0] q_out_data;
    logic [ROW_W-1:0]          row_index;
    logic [OUT_W*NUM_COLS-1:0] entries;

    // Hold the derivative direction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            direction_reg <= 1'b0;
        else if (cfg_wr_en)
            direction_reg <= cfg_wr_data;
    end

    p2p1d_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .direction (direction_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .vertex0_x (s_tdata[0*COORD_BITS +: COORD_BITS]),
        .vertex0_y (s_tdata[1*COORD_BITS +: COORD_BITS]),
        .vertex1_x (s_tdata[2*COORD_BITS +: COORD_BITS]),
        .vertex1_y (s_tdata[3*COORD_BITS +: COORD_BITS]),
        .vertex2_x (s_tdata[4*COORD_BITS +: COORD_BITS]),
        .vertex2_y (s_tdata[5*COORD_BITS +: COORD_BITS]),
        .out_valid (q_in_valid),
        .out_ready (q_in_ready),
        .out_data  (q_in_data)
    );

    p2p1d_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    p2p1d_back #(.COORD_BITS(COORD_BITS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_out_valid),
        .in_ready   (q_out_ready),
        .in_data    (q_out_data),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .row_index  (row_index),
        .entries    (entries),
        .degenerate (m_tuser),
        .last_row   (m_tlast)
    );

    assign m_tdata = {(296 - DATA_BITS)'(0), entries, row_index};

`ifndef SYNTHESIS
    // The closing row is always the third one
    a_last_row: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == ROW_LAST)))
        else $error("tlast does not match row index");

    // A degenerate triangle carries only zero entries
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[DATA_BITS-1:ROW_W] == '0))
        else $error("degenerate row with nonzero entries");

    // Rows of one triangle follow without a gap, in order
    a_row_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
            (m_tvalid && (m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1)))
        else $error("row sequence broken");

    // The queue only drains on the closing row
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (q_out_valid && q_out_ready) |=> (m_tvalid && m_tlast))
        else $error("queue popped before the closing row");
`endif

endmodule
